@@ rtl/core/dbs_pkg.sv @@
// Shared types and constants for the debug breakpoint and step unit.
package dbs_pkg;

	// Fixed field widths of the item ports
	localparam int unsigned MODE_W       = 3;
	localparam int unsigned ADDR_FIELD_W = 32;

	// Defaults for the top-level parameters
	localparam int unsigned BP_SLOTS_DEF  = 8;
	localparam int unsigned ADDR_BITS_DEF = 32;

	// Item kinds; the remaining codes are ignored
	typedef enum logic [MODE_W-1:0] {
		MODE_TICK     = 3'd0,
		MODE_SET      = 3'd1,
		MODE_CLEAR    = 3'd2,
		MODE_CONTINUE = 3'd3,
		MODE_STEP     = 3'd4
	} dbs_mode_t;

	// Lookup result from the breakpoint table
	typedef struct packed {
		logic match;  // some valid slot holds the address
		logic full;   // no free slot left
	} dbs_tbl_stat_t;

	// Run-control result for the item in flight
	typedef struct packed {
		logic stop;   // trap stop reported
		logic paused; // pause flag after the item
		logic hit;    // latched hit after the item
	} dbs_run_stat_t;

endpackage

@@ rtl/core/debug_breakpoint_step_unit.sv @@
// Top level of the debug breakpoint and single-step unit.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------
//  cmd     | cmd_valid | cmd_stall | mode, address
//  rsp     | rsp_valid | rsp_stall | status, stop_report, paused, hit_latched
//
// One item per cycle unless stalled; input register, then result register.
// The slot compare and the flag update sit between the two registers.
// Reset clears slot valid bits and flags at once; no sweep is needed.
// A stalled result holds the result register; cmd_stall rises only when
// the input register is full and the result cannot move.
module debug_breakpoint_step_unit #(
	parameter int unsigned BREAKPOINT_SLOTS = dbs_pkg::BP_SLOTS_DEF,
	parameter int unsigned ADDR_BITS        = dbs_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic [dbs_pkg::MODE_W-1:0]        mode,
	input  logic [dbs_pkg::ADDR_FIELD_W-1:0]  address,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              status,
	output logic                              stop_report,
	output logic                              paused,
	output logic                              hit_latched
);
	import dbs_pkg::*;

	// Address bits that take part in the compare
	localparam int unsigned AW = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;

	logic                    valid_s1;
	logic [MODE_W-1:0]       mode_s1;
	logic [AW-1:0]           addr_s1;
	logic                    valid_s2;
	logic                    status_s2, stop_s2, paused_s2, hit_s2;
	logic                    advance;
	logic                    fire;
	dbs_mode_t               mode_e;
	dbs_tbl_stat_t           tbl;
	dbs_run_stat_t           run;

	// Stage one moves on when the result register is free or being taken
	assign advance   = !valid_s2 || !rsp_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;
	assign mode_e    = dbs_mode_t'(mode_s1);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			mode_s1 <= mode;
			addr_s1 <= address[AW-1:0];
		end
	end

	dbs_bp_table #(
		.SLOTS (BREAKPOINT_SLOTS),
		.AW    (AW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.mode   (mode_e),
		.addr   (addr_s1),
		.stat   (tbl)
	);

	dbs_run_ctrl u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.mode   (mode_e),
		.match  (tbl.match),
		.run    (run)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= (mode_e == MODE_SET) && !tbl.match && tbl.full;
			stop_s2   <= run.stop;
			paused_s2 <= run.paused;
			hit_s2    <= run.hit;
		end
	end

	assign rsp_valid   = valid_s2;
	assign status      = status_s2;
	assign stop_report = stop_s2;
	assign paused      = paused_s2;
	assign hit_latched = hit_s2;

`ifndef NO_ASSERTIONS
	// A reported stop always leaves the CPU paused
	a_stop_paused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && stop_report |-> paused)
		else $error("stop reported without pause");

	// A full-table status never comes with a stop
	a_status_no_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> !stop_report)
		else $error("status and stop together");

	// A reported hit always comes with the pause flag
	a_hit_paused_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit_latched |-> paused)
		else $error("hit reported without pause");
`endif

endmodule

@@ rtl/core/dbs_bp_table.sv @@
// Breakpoint slot table: parallel address compare, insert into lowest free slot, remove.
module dbs_bp_table #(
	parameter int unsigned SLOTS = dbs_pkg::BP_SLOTS_DEF,
	parameter int unsigned AW    = dbs_pkg::ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  dbs_pkg::dbs_mode_t    mode,
	input  logic [AW-1:0]         addr,
	output dbs_pkg::dbs_tbl_stat_t stat
);
	import dbs_pkg::*;

	logic [AW-1:0]    slot_addr_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] match;
	logic [SLOTS-1:0] free;
	logic [SLOTS-1:0] first_free;
	logic             do_insert;
	logic             do_remove;

	// Compare every slot against the item address
	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			match[k] = valid_q[k] && (slot_addr_q[k] == addr);
		end
	end

	// Lowest free slot as a one-hot mask
	assign free       = ~valid_q;
	assign first_free = free & (~free + SLOTS'(1));

	assign stat.match = |match;
	assign stat.full  = ~|free;

	assign do_insert = fire && (mode == MODE_SET) && !stat.match && !stat.full;
	assign do_remove = fire && (mode == MODE_CLEAR);

	// Slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_insert) begin
			valid_q <= valid_q | first_free;
		end else if (do_remove) begin
			valid_q <= valid_q & ~match;
		end
	end

	// Slot addresses, written only into the slot being claimed
	always_ff @(posedge clk) begin
		for (int k = 0; k < SLOTS; k++) begin
			if (do_insert && first_free[k]) begin
				slot_addr_q[k] <= addr;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// An insert claims exactly one previously free slot
	a_insert_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |-> $onehot(first_free))
		else $error("insert without a single free slot");

	// An insert adds exactly one valid slot
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> ($countones(valid_q) == $countones($past(valid_q)) + 1))
		else $error("insert did not add one slot");

	// A set of an address already present leaves the table alone
	a_dup_set: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (mode == MODE_SET) && stat.match |=> $stable(valid_q))
		else $error("duplicate set changed the table");
`endif

endmodule

@@ rtl/core/dbs_run_ctrl.sv @@
// Run control: latched hit, pause flag and single-step budget.
module dbs_run_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  dbs_pkg::dbs_mode_t     mode,
	input  logic                   match,
	output dbs_pkg::dbs_run_stat_t run
);
	import dbs_pkg::*;

	logic hit_q, pause_q, step_q;
	logic hit_d, pause_d, step_d, stop_d;

	// Next flags for the item in stage one
	always_comb begin
		hit_d   = hit_q;
		pause_d = pause_q;
		step_d  = step_q;
		stop_d  = 1'b0;
		unique case (mode)
			MODE_TICK: begin
				if (!hit_q && match) begin
					hit_d  = 1'b1;
					stop_d = 1'b1;
				end
				if (hit_d) begin
					// breakpoint wins over a pending step
					pause_d = 1'b1;
					step_d  = 1'b0;
				end else if (!pause_q && step_q) begin
					step_d  = 1'b0;
					pause_d = 1'b1;
					stop_d  = 1'b1;
				end
			end
			MODE_CONTINUE: begin
				pause_d = 1'b0;
				hit_d   = 1'b0;
			end
			MODE_STEP: begin
				step_d  = 1'b1;
				pause_d = 1'b0;
				hit_d   = 1'b0;
			end
			default: begin
				// set, clear and unused codes leave the flags alone
			end
		endcase
	end

	assign run.stop   = stop_d;
	assign run.paused = pause_d;
	assign run.hit    = hit_d;

	// Flag registers, updated as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			pause_q <= 1'b0;
			step_q  <= 1'b0;
		end else if (fire) begin
			hit_q   <= hit_d;
			pause_q <= pause_d;
			step_q  <= step_d;
		end
	end

`ifndef NO_ASSERTIONS
	// A latched hit always holds the CPU
	a_hit_paused: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> pause_q)
		else $error("hit latched without pause");

	// A pending step never survives a latched hit
	a_hit_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> !step_q)
		else $error("step pending while hit latched");

	// A hit is only latched by a tick
	a_hit_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_q) |-> $past(fire && (mode == MODE_TICK)))
		else $error("hit latched by a non-tick item");
`endif

endmodule
